// File: src/lesf_pkg.sv
// lesf_pkg: shared widths, register indexes and reset values for the
// largest empty square finder; no dependencies
`default_nettype none

package lesf_pkg;

    // fixed field widths
    localparam int unsigned CHAR_W    = 8;
    localparam int unsigned SIDE_W    = 11;
    localparam int unsigned POS_W     = 10;
    localparam int unsigned CFG_W     = 11;
    localparam int unsigned CFG_IDX_W = 2;

    // map limits and defaults
    localparam int unsigned ROW_LIMIT    = 1024;
    localparam int unsigned MAX_COLS_DEF = 1024;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_CHAR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd2;

    // register reset values
    localparam logic [CHAR_W-1:0] EMPTY_CHAR_RST = 8'd46;

endpackage : lesf_pkg

`default_nettype wire

// File: src/lesf_line_store.sv
// lesf_line_store: previous-row side values, one read and one write per cycle
// read data registered, same-cycle write to the read address is forwarded
`default_nettype none

module lesf_line_store #(
    parameter int unsigned DEPTH  = lesf_pkg::MAX_COLS_DEF,
    parameter int unsigned ADDR_W = 10
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        rd_en,
    input  wire logic [ADDR_W-1:0]           rd_addr,
    output logic      [lesf_pkg::SIDE_W-1:0] rd_data,
    input  wire logic                        wr_en,
    input  wire logic [ADDR_W-1:0]           wr_addr,
    input  wire logic [lesf_pkg::SIDE_W-1:0] wr_data
);
    import lesf_pkg::*;

    logic [SIDE_W-1:0] mem [DEPTH];
    logic [SIDE_W-1:0] ram_q_reg;
    logic [SIDE_W-1:0] fwd_data_reg;
    logic              fwd_reg;

    // storage array, read-before-write
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            ram_q_reg    <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // bypass flag: write landing on the address being read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else if (rd_en) begin
            fwd_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = fwd_reg ? fwd_data_reg : ram_q_reg;

endmodule : lesf_line_store

`default_nettype wire

// File: src/largest_empty_square_finder_top.sv
// largest_empty_square_finder_top: streaming maximal-square search over a map
// depends on lesf_pkg and lesf_line_store
// throughput: one cell transfer per cycle unless a finished map waits on a full output register;
// line store read and written once per cell; the result loads the output register from stage 1
// reset: synchronous active-low aresetn restores register defaults and clears counters
// the line store is not cleared, row 0 writes every entry it reads
`default_nettype none

module largest_empty_square_finder_top #(
    parameter int unsigned MAX_COLS = lesf_pkg::MAX_COLS_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // configuration write port
    input  wire logic                           cfg_we,
    input  wire logic [lesf_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  wire logic [lesf_pkg::CFG_W-1:0]     cfg_wdata,
    // cell input channel
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic [lesf_pkg::CHAR_W-1:0]    s_cell_req,
    // result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic      [lesf_pkg::SIDE_W-1:0]    m_square_size,
    output logic      [lesf_pkg::POS_W-1:0]     m_corner_col,
    output logic      [lesf_pkg::POS_W-1:0]     m_corner_row
);
    import lesf_pkg::*;

    localparam int unsigned COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    // count width: holds column_count and MAX_COLS itself
    localparam int unsigned CNT_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;

    // flags and position of the cell in the update stage
    typedef struct packed {
        logic             empty;
        logic             up_ok;    // not in the first row
        logic             col_ok;   // not in the first column
        logic             row_end;
        logic             map_end;
        logic [COL_W-1:0] col;
        logic [POS_W-1:0] row;
    } s1_t;

    // ---------------------------------------------------------------
    // configuration registers, counts stored already clamped
    // ---------------------------------------------------------------
    logic [CHAR_W-1:0] empty_char_reg;
    logic [CFG_W-1:0]  rows_reg;
    logic [CNT_W-1:0]  cols_reg;
    logic [CFG_W-1:0]  rows_clamped;
    logic [CNT_W-1:0]  cols_clamped;
    logic [CNT_W-1:0]  cfg_cnt_ext;

    assign cfg_cnt_ext = CNT_W'(cfg_wdata);

    always_comb begin
        priority if (cfg_wdata == '0) begin
            rows_clamped = CFG_W'(1);
        end else if (cfg_wdata > CFG_W'(ROW_LIMIT)) begin
            rows_clamped = CFG_W'(ROW_LIMIT);
        end else begin
            rows_clamped = cfg_wdata;
        end
        priority if (cfg_cnt_ext == '0) begin
            cols_clamped = CNT_W'(1);
        end else if (cfg_cnt_ext > CNT_W'(MAX_COLS)) begin
            cols_clamped = CNT_W'(MAX_COLS);
        end else begin
            cols_clamped = cfg_cnt_ext;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            empty_char_reg <= EMPTY_CHAR_RST;
            rows_reg       <= CFG_W'(1);
            cols_reg       <= CNT_W'(1);
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_EMPTY_CHAR:   empty_char_reg <= cfg_wdata[CHAR_W-1:0];
                REG_ROW_COUNT:    rows_reg       <= rows_clamped;
                REG_COLUMN_COUNT: cols_reg       <= cols_clamped;
                default: ;        // unused index, write dropped
            endcase
        end
    end

    // ---------------------------------------------------------------
    // stage 0: accept a cell, advance position, issue line store read
    // ---------------------------------------------------------------
    logic             s_fire;
    logic             s1_fire;
    logic             s1_valid_reg;
    s1_t              s1_reg;
    logic [COL_W-1:0] col_pos_reg;
    logic [POS_W-1:0] row_pos_reg;
    logic [CNT_W-1:0] col_inc;
    logic [CFG_W-1:0] row_inc;
    logic             row_end0;
    logic             map_end0;
    logic             m_valid_reg;

    assign col_inc  = CNT_W'(col_pos_reg) + CNT_W'(1);
    assign row_inc  = CFG_W'(row_pos_reg) + CFG_W'(1);
    assign row_end0 = (col_inc >= cols_reg);
    assign map_end0 = row_end0 && (row_inc >= rows_reg);

    // update stage holds only when a finished map meets a full output register
    assign s1_fire = s1_valid_reg && !(s1_reg.map_end && m_valid_reg && !m_ready);
    assign s_ready = !s1_valid_reg || s1_fire;
    assign s_fire  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                s1_valid_reg <= 1'b1;
                if (row_end0) begin
                    col_pos_reg <= '0;
                    row_pos_reg <= map_end0 ? '0 : POS_W'(row_inc);
                end else begin
                    col_pos_reg <= COL_W'(col_inc);
                end
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // stage payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_reg.empty   <= (s_cell_req == empty_char_reg);
            s1_reg.up_ok   <= (row_pos_reg != '0);
            s1_reg.col_ok  <= (col_pos_reg != '0);
            s1_reg.row_end <= row_end0;
            s1_reg.map_end <= map_end0;
            s1_reg.col     <= col_pos_reg;
            s1_reg.row     <= row_pos_reg;
        end
    end

    // ---------------------------------------------------------------
    // line store: read at accept, write back from the update stage
    // ---------------------------------------------------------------
    logic [SIDE_W-1:0] up_raw;
    logic [SIDE_W-1:0] side;

    lesf_line_store #(
        .DEPTH  (MAX_COLS),
        .ADDR_W (COL_W)
    ) u_line_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (s_fire),
        .rd_addr (col_pos_reg),
        .rd_data (up_raw),
        .wr_en   (s1_fire),
        .wr_addr (s1_reg.col),
        .wr_data (side)
    );

    // ---------------------------------------------------------------
    // stage 1: side value, best-square tracking, result load
    // ---------------------------------------------------------------
    logic [SIDE_W-1:0] left_side_reg;
    logic [SIDE_W-1:0] diag_side_reg;
    logic [SIDE_W-1:0] best_size_reg;
    logic [POS_W-1:0]  best_col_reg;
    logic [POS_W-1:0]  best_row_reg;
    logic [SIDE_W-1:0] up;
    logic [SIDE_W-1:0] min_ul;
    logic [SIDE_W-1:0] min3;
    logic              better;
    logic [SIDE_W-1:0] new_size;
    logic [POS_W-1:0]  new_col;
    logic [POS_W-1:0]  new_row;
    logic [POS_W-1:0]  s1_col_pos;
    logic [POS_W-1:0]  side_pos;

    // first row sees an up value of zero
    assign up     = s1_reg.up_ok ? up_raw : '0;
    assign min_ul = (up < left_side_reg) ? up : left_side_reg;
    assign min3   = (min_ul < diag_side_reg) ? min_ul : diag_side_reg;

    always_comb begin
        if (!s1_reg.empty) begin
            side = '0;
        end else if (s1_reg.up_ok && s1_reg.col_ok) begin
            side = min3 + SIDE_W'(1);
        end else begin
            side = SIDE_W'(1);
        end
    end

    // corner = position + 1 - side, modulo the position width
    assign s1_col_pos = POS_W'(CNT_W'(s1_reg.col));
    assign side_pos   = side[POS_W-1:0];
    assign better     = (side > best_size_reg);
    assign new_size   = better ? side : best_size_reg;
    assign new_col    = better ? (s1_col_pos + POS_W'(1) - side_pos) : best_col_reg;
    assign new_row    = better ? (s1_reg.row + POS_W'(1) - side_pos) : best_row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_side_reg <= '0;
            diag_side_reg <= '0;
            best_size_reg <= '0;
            best_col_reg  <= '0;
            best_row_reg  <= '0;
        end else if (s1_fire) begin
            // neighbors restart at each row
            left_side_reg <= s1_reg.row_end ? '0 : side;
            diag_side_reg <= s1_reg.row_end ? '0 : up;
            if (s1_reg.map_end) begin
                best_size_reg <= '0;
                best_col_reg  <= '0;
                best_row_reg  <= '0;
            end else begin
                best_size_reg <= new_size;
                best_col_reg  <= new_col;
                best_row_reg  <= new_row;
            end
        end
    end

    // output register: result waits here while cells keep flowing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_fire && s1_reg.map_end) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_reg.map_end) begin
            m_square_size <= new_size;
            m_corner_col  <= new_col;
            m_corner_row  <= new_row;
        end
    end

    assign m_valid = m_valid_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (s1_valid_reg && s1_reg.map_end && m_valid_reg && !m_ready))
        else $error("input stalled without a blocked result");

    a_map_end_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_reg.map_end) |-> s1_reg.row_end)
        else $error("map end outside the last column");

    a_result_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_fire && s1_reg.map_end) |=> m_valid_reg)
        else $error("finished map produced no result");

    a_counters_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && map_end0) |=> (col_pos_reg == '0 && row_pos_reg == '0))
        else $error("position counters not cleared after last cell");

    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        CNT_W'(col_pos_reg) < cols_reg)
        else $error("column position beyond column count");

endmodule : largest_empty_square_finder_top

`default_nettype wire
